### sv/i26wl_pkg.sv
package i26wl_pkg;

    localparam int COEF_WIDTH       = 16;
    localparam int CLIP_WIDTH       = 5;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Width of a weighted low sum: 16 times the largest coefficient plus margin.
    localparam int TAPS_WIDTH = COEF_WIDTH + 6;
    // Width of the part added to the smoothing term: a low plus or minus a high.
    localparam int REST_WIDTH = COEF_WIDTH + 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

    // Kinds of sample-pair work handed from the front end to the back end.
    localparam logic [1:0] KIND_FIRST    = 2'd0;
    localparam logic [1:0] KIND_INTERIOR = 2'd1;
    localparam logic [1:0] KIND_LAST     = 2'd2;
    localparam logic [1:0] KIND_SHORT    = 2'd3;

    typedef struct packed {
        logic [1:0]                   kind;
        logic signed [COEF_WIDTH-1:0] a;
        logic signed [COEF_WIDTH-1:0] b;
        logic signed [COEF_WIDTH-1:0] c;
        logic signed [COEF_WIDTH-1:0] h;
    } job_t;

endpackage

### sv/i26wl_front.sv
module i26wl_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [i26wl_pkg::COEF_WIDTH-1:0] low_coef,
    input  logic signed [i26wl_pkg::COEF_WIDTH-1:0] high_coef,
    input  logic                                    line_end,
    output logic                                    push,
    output i26wl_pkg::job_t                         push_job,
    input  logic                                    queue_full
);
    import i26wl_pkg::*;

    logic signed [COEF_WIDTH-1:0] low_prev1_reg;
    logic signed [COEF_WIDTH-1:0] low_prev2_reg;
    logic signed [COEF_WIDTH-1:0] high_prev1_reg;
    logic signed [COEF_WIDTH-1:0] high_prev2_reg;
    logic [1:0]                   pos_count_reg;
    logic [1:0]                   pos_count_next;
    logic [1:0]                   job_idx_reg;
    logic [1:0]                   job_idx_next;
    logic [1:0]                   num_jobs;
    logic                         last_job;
    logic                         accept;

    // Number of sample pairs that this coefficient pair releases.
    always_comb
    begin
        case (pos_count_reg)
            2'd0, 2'd1: num_jobs = line_end ? 2'd1 : 2'd0;
            2'd2:       num_jobs = line_end ? 2'd3 : 2'd2;
            default:    num_jobs = line_end ? 2'd2 : 2'd1;
        endcase
    end

    always_comb
    begin
        push_job.a = low_prev2_reg;
        push_job.b = low_prev1_reg;
        push_job.c = low_coef;
        push_job.h = high_prev1_reg;
        if (pos_count_reg < 2'd2) begin
            push_job.kind = KIND_SHORT;
        end else if (pos_count_reg == 2'd2 && job_idx_reg == 2'd0) begin
            push_job.kind = KIND_FIRST;
            push_job.h    = high_prev2_reg;
        end else if ((pos_count_reg == 2'd2 && job_idx_reg == 2'd1) ||
                     (pos_count_reg == 2'd3 && job_idx_reg == 2'd0)) begin
            push_job.kind = KIND_INTERIOR;
        end else begin
            push_job.kind = KIND_LAST;
            push_job.a    = low_coef;
            push_job.c    = low_prev2_reg;
            push_job.h    = high_coef;
        end
    end

    assign last_job = (job_idx_reg == num_jobs - 2'd1);
    assign push     = in_valid && (num_jobs != 2'd0);
    assign in_ready = (num_jobs == 2'd0) || (!queue_full && last_job);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        job_idx_next = job_idx_reg;
        if (accept) begin
            job_idx_next = 2'd0;
        end else if (push && !queue_full) begin
            job_idx_next = job_idx_reg + 2'd1;
        end
    end

    always_comb
    begin
        if (line_end) begin
            pos_count_next = 2'd0;
        end else if (pos_count_reg != 2'd3) begin
            pos_count_next = pos_count_reg + 2'd1;
        end else begin
            pos_count_next = pos_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_count_reg  <= 2'd0;
            job_idx_reg    <= 2'd0;
            low_prev1_reg  <= '0;
            low_prev2_reg  <= '0;
            high_prev1_reg <= '0;
            high_prev2_reg <= '0;
        end else begin
            job_idx_reg <= job_idx_next;
            if (accept) begin
                pos_count_reg  <= pos_count_next;
                low_prev2_reg  <= low_prev1_reg;
                low_prev1_reg  <= low_coef;
                high_prev2_reg <= high_prev1_reg;
                high_prev1_reg <= high_coef;
            end
        end
    end

endmodule

### sv/i26wl_queue.sv
module i26wl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i26wl_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output i26wl_pkg::job_t head_job
);
    import i26wl_pkg::*;

    job_t                  mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QPTR_WIDTH:0]   count_reg;
    logic [QPTR_WIDTH:0]   count_next;
    logic                  push_do;
    logic                  pop_do;

    assign full       = (count_reg == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign push_do    = push && !full;
    assign pop_do     = pop && head_valid;

    always_comb
    begin
        case ({push_do, pop_do})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push_do) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_do) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_do) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

### sv/i26wl_back.sv
module i26wl_back #(
    parameter int SAMPLE_WIDTH = i26wl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [i26wl_pkg::CLIP_WIDTH-1:0]    clip_bits,
    input  logic                                head_valid,
    input  i26wl_pkg::job_t                     head_job,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      sample,
    output logic                                line_done,
    output logic                                short_line
);
    import i26wl_pkg::*;

    localparam int TW = TAPS_WIDTH;
    localparam int RW = REST_WIDTH;
    localparam int XW = ((SAMPLE_WIDTH > TW) ? SAMPLE_WIDTH : TW) + 2;
    localparam logic signed [TW-1:0] TAPS_ZERO = TW'(-4);

    logic                          advance;
    logic                          phase_reg;
    logic signed [TW-1:0]          ax;
    logic signed [TW-1:0]          bx;
    logic signed [TW-1:0]          cx;
    logic signed [RW-1:0]          hx;
    logic signed [RW-1:0]          base;
    logic signed [TW-1:0]          taps_u;
    logic signed [TW-1:0]          taps_v;
    logic signed [TW-1:0]          taps_d;
    logic signed [TW-1:0]          taps;
    logic signed [RW-1:0]          rest;
    logic                          done;
    logic                          is_short;
    logic                          pair_end;

    logic                          a_valid_reg;
    logic signed [TW-1:0]          taps_reg;
    logic signed [RW-1:0]          rest_reg;
    logic                          done_reg;
    logic                          short_reg;

    logic signed [XW-1:0]          tsum;
    logic signed [XW-1:0]          tshift;
    logic signed [SAMPLE_WIDTH-1:0] term;
    logic signed [XW-1:0]          ssum;
    logic signed [XW-1:0]          sshift;
    logic signed [SAMPLE_WIDTH-1:0] wrapped;
    logic [SAMPLE_WIDTH-1:0]       top;
    logic signed [SAMPLE_WIDTH-1:0] clamped;

    logic                          out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                          line_done_reg;
    logic                          short_line_reg;

    // The whole two-stage pipe moves when the output register is free.
    assign advance = !out_valid_reg || out_ready;

    assign ax = {{(TW-COEF_WIDTH){head_job.a[COEF_WIDTH-1]}}, head_job.a};
    assign bx = {{(TW-COEF_WIDTH){head_job.b[COEF_WIDTH-1]}}, head_job.b};
    assign cx = {{(TW-COEF_WIDTH){head_job.c[COEF_WIDTH-1]}}, head_job.c};
    assign hx = {{(RW-COEF_WIDTH){head_job.h[COEF_WIDTH-1]}}, head_job.h};

    // Boundary weights 11,-4,1 and 5,4,-1 as shifts and adds.
    assign taps_u = (ax <<< 3) + (ax <<< 1) + ax - (bx <<< 2) + cx;
    assign taps_v = (ax <<< 2) + ax + (bx <<< 2) - cx;
    assign taps_d = ax - cx;

    always_comb
    begin
        base     = '0;
        is_short = 1'b0;
        done     = 1'b0;
        case (head_job.kind)
            KIND_FIRST: begin
                taps = phase_reg ? taps_v : taps_u;
            end
            KIND_INTERIOR: begin
                taps = phase_reg ? -taps_d : taps_d;
                base = {{(RW-COEF_WIDTH){head_job.b[COEF_WIDTH-1]}}, head_job.b};
            end
            KIND_LAST: begin
                taps = phase_reg ? taps_u : taps_v;
                done = phase_reg;
            end
            default: begin
                taps     = TAPS_ZERO;
                is_short = 1'b1;
                done     = 1'b1;
            end
        endcase
        if (is_short) begin
            rest = '0;
        end else if (phase_reg) begin
            rest = base - hx;
        end else begin
            rest = base + hx;
        end
    end

    // A short-line marker is a single transfer; every other job gives two.
    assign pair_end = is_short || phase_reg;
    assign pop      = advance && head_valid && pair_end;

    assign tsum    = {{(XW-TW){taps_reg[TW-1]}}, taps_reg} + XW'(4);
    assign tshift  = tsum >>> 3;
    assign term    = tshift[SAMPLE_WIDTH-1:0];
    assign ssum    = {{(XW-SAMPLE_WIDTH){term[SAMPLE_WIDTH-1]}}, term}
                   + {{(XW-RW){rest_reg[RW-1]}}, rest_reg};
    assign sshift  = ssum >>> 1;
    assign wrapped = sshift[SAMPLE_WIDTH-1:0];
    assign top     = ~({SAMPLE_WIDTH{1'b1}} << clip_bits);

    always_comb
    begin
        clamped = wrapped;
        if (clip_bits != '0) begin
            if (wrapped[SAMPLE_WIDTH-1]) begin
                clamped = '0;
            end else if ($unsigned(wrapped) > top) begin
                clamped = $signed(top);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            taps_reg       <= taps;
            rest_reg       <= rest;
            done_reg       <= done;
            short_reg      <= is_short;
            sample_reg     <= clamped;
            line_done_reg  <= done_reg;
            short_line_reg <= short_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= 1'b0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg   <= head_valid;
            out_valid_reg <= a_valid_reg;
            if (head_valid) begin
                phase_reg <= !pair_end;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample     = sample_reg;
    assign line_done  = line_done_reg;
    assign short_line = short_line_reg;

endmodule

### sv/inverse_26_wavelet_line.sv
// Inverse 2/6 wavelet synthesis over one line. Each input transfer carries one
// low-band and one high-band coefficient, with line_end on the last pair; each
// pair becomes two samples, even then odd, one output transfer per cycle while
// out_ready allows, from the single sample datapath in the back end; new pairs
// can enter while earlier work waits in the job queue. Interior samples need
// the following low, so they appear one pair late; the first two pairs of a
// line give nothing, the third gives two positions and a line_end pair adds
// its own position, holding the input while that work enters the four-entry
// job queue. A line of fewer than three pairs gives one transfer with sample
// zero, line_done and short_line set. A job's even sample passes taps_reg,
// then the output register, after the job reaches the queue head, and the odd
// sample follows. clip_bits must be written only while idle (not enforced by
// the block); when nonzero it clamps samples to 0..2^clip_bits-1.
module inverse_26_wavelet_line #(
    parameter int SAMPLE_WIDTH = i26wl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [i26wl_pkg::CLIP_WIDTH-1:0]        cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [i26wl_pkg::COEF_WIDTH-1:0] low_coef,
    input  logic signed [i26wl_pkg::COEF_WIDTH-1:0] high_coef,
    input  logic                                    line_end,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]          sample,
    output logic                                    line_done,
    output logic                                    short_line
);
    import i26wl_pkg::*;

    logic [CLIP_WIDTH-1:0] clip_bits_reg;
    logic                  push;
    job_t                  push_job;
    logic                  queue_full;
    logic                  pop;
    logic                  head_valid;
    job_t                  head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clip_bits_reg <= '0;
        end else if (cfg_we) begin
            clip_bits_reg <= cfg_data;
        end
    end

    i26wl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .low_coef   (low_coef),
        .high_coef  (high_coef),
        .line_end   (line_end),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    i26wl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    i26wl_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clip_bits  (clip_bits_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample),
        .line_done  (line_done),
        .short_line (short_line)
    );

endmodule
